FILE: sv/acmm_pkg.sv
// shared types, constants and register indexes of the channel mixing matrix
package acmm_pkg;

  // defaults of the top level parameters
  localparam int MAX_CHANNELS_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int COEF_BITS_DEF    = 24;

  // fixed widths of the block
  localparam int ACC_BITS   = 48;
  localparam int CH_W       = 4;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 5;

  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_COUNT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 4'd1;

  // operation codes of an input word
  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic            clear_step;
    logic            coef_we;
    logic            sample_load;
    logic            mac_issue;
    logic [CH_W-1:0] mac_row;
    logic [CH_W-1:0] mac_col;
    logic            emit_load;
    logic [CH_W-1:0] emit_row;
    logic            emit_last;
    logic            frame_clear;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic busy;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/acmm_ram.sv
// generic single write port, single read port ram with registered read
module acmm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/acmm_ctrl.sv
// controller of the channel mixing matrix: clearing pass, mac issue, emission
module acmm_ctrl import acmm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             operation_i,
  input  logic [CNT_W-1:0] in_count_i,
  input  logic [CNT_W-1:0] out_count_i,
  input  logic             cfg_clear_i,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  state_e          state_q, state_d;
  logic [CH_W-1:0] row_q, row_d;
  logic [CH_W-1:0] pos_q, pos_d;
  logic            last_row;
  logic            frame_end;

  assign last_row  = ((CNT_W'(row_q) + 5'd1) == out_count_i);
  assign frame_end = ((CNT_W'(pos_q) + 5'd1) == in_count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      row_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      pos_q   <= pos_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    pos_d      = pos_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (operation_i == OP_SAMPLE) begin
            cmd_o.sample_load = 1'b1;
            row_d   = '0;
            state_d = ST_MAC;
          end else begin
            cmd_o.coef_we = 1'b1;
          end
        end
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.mac_row   = row_q;
        cmd_o.mac_col   = pos_q;
        row_d = row_q + 1'b1;
        if (last_row) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last product to land in its accumulator
        if (!sts_i.busy) begin
          row_d = '0;
          if (frame_end) begin
            pos_d   = '0;
            state_d = ST_EMIT;
          end else begin
            pos_d   = pos_q + 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.emit_row  = row_q;
          cmd_o.emit_last = last_row;
          row_d = row_q + 1'b1;
          if (last_row) begin
            cmd_o.frame_clear = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // a register write abandons the partial frame
    if (cfg_clear_i) begin
      cmd_o.frame_clear = 1'b1;
      pos_d = '0;
    end
  end

`ifndef SYNTHESIS
  a_mac_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mac_issue |-> (CNT_W'(cmd_o.mac_row) < out_count_i))
    else $error("mac issued beyond the output channel count");

  a_emit_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_load |-> !sts_i.busy)
    else $error("emission while products are still in flight");

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W'(pos_q) < in_count_i))
    else $error("input position beyond the input channel count");

  a_last_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_load && cmd_o.emit_last) |=> (state_q == ST_IDLE))
    else $error("controller not idle after the last word of a frame");
`endif

endmodule

FILE: sv/acmm_dp.sv
// datapath of the channel mixing matrix: coefficient store, mac pipe, saturation
module acmm_dp import acmm_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int COEF_BITS    = COEF_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmd_t                          cmd_i,
  output sts_t                          sts_o,
  input  logic [CH_W-1:0]               coef_row_i,
  input  logic [CH_W-1:0]               coef_col_i,
  input  logic signed [COEF_BITS-1:0]   coef_value_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [CH_W-1:0]               out_channel_o,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          clipped_o,
  output logic                          last_of_frame_o
);

  localparam int DEPTH    = MAX_CHANNELS * MAX_CHANNELS;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CH_LIMIT = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;
  localparam int AIW      = (CH_LIMIT > 1) ? $clog2(CH_LIMIT) : 1;
  localparam int PW       = COEF_BITS + SAMPLE_BITS;
  localparam int FRAC     = COEF_BITS - 8;
  localparam logic [ACC_BITS-1:0] MAX_MAG =
    {{(ACC_BITS-SAMPLE_BITS){1'b0}}, 1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // clearing pass counter
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // coefficient store
  logic                 coef_ok;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [COEF_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [COEF_BITS-1:0] ram_rdata;

  assign coef_ok   = (32'(coef_row_i) < MAX_CHANNELS) && (32'(coef_col_i) < MAX_CHANNELS);
  assign ram_we    = cmd_i.clear_step || (cmd_i.coef_we && coef_ok);
  assign ram_waddr = cmd_i.clear_step ? clr_cnt_q
                   : AW'(32'(coef_row_i) * MAX_CHANNELS + 32'(coef_col_i));
  assign ram_wdata = cmd_i.clear_step ? '0 : coef_value_i;
  assign ram_raddr = AW'(32'(cmd_i.mac_row) * MAX_CHANNELS + 32'(cmd_i.mac_col));

  acmm_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // mac pipe: read, multiply, accumulate
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          s1_valid_q, s2_valid_q;
  logic [CH_W-1:0]               s1_row_q, s2_row_q;
  logic signed [PW-1:0]          prod_full;
  logic signed [ACC_BITS-1:0]    prod_ext;
  logic signed [ACC_BITS-1:0]    prod_q;
  logic signed [ACC_BITS-1:0]    acc_q [CH_LIMIT];

  assign prod_full = PW'(signed'(ram_rdata)) * PW'(sample_q);

  if (PW >= ACC_BITS) begin : g_prod_trunc
    assign prod_ext = prod_full[ACC_BITS-1:0];
  end else begin : g_prod_sext
    assign prod_ext = ACC_BITS'(prod_full);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_load) begin
      sample_q <= sample_in_i;
    end
    s1_row_q <= cmd_i.mac_row;
    s2_row_q <= s1_row_q;
    prod_q   <= prod_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.mac_issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CH_LIMIT; i++) begin
        acc_q[i] <= '0;
      end
    end else if (cmd_i.frame_clear) begin
      for (int i = 0; i < CH_LIMIT; i++) begin
        acc_q[i] <= '0;
      end
    end else if (s2_valid_q) begin
      acc_q[s2_row_q[AIW-1:0]] <= acc_q[s2_row_q[AIW-1:0]] + prod_q;
    end
  end

  // truncate toward zero, then saturate
  logic signed [ACC_BITS-1:0] acc_rd;
  logic                       neg;
  logic [ACC_BITS-1:0]        abs_v;
  logic [ACC_BITS-1:0]        mag;
  logic [ACC_BITS-1:0]        mag_sat;
  logic [ACC_BITS-1:0]        res_full;
  logic                       clip;

  always_comb begin
    acc_rd = acc_q[cmd_i.emit_row[AIW-1:0]];
    neg    = acc_rd[ACC_BITS-1];
    abs_v  = neg ? (~acc_rd + 1'b1) : acc_rd;
    mag    = abs_v >> FRAC;
    if (neg) begin
      clip = (mag > MAX_MAG);
    end else begin
      clip = (mag > (MAX_MAG - 1'b1));
    end
    if (clip) begin
      mag_sat = neg ? MAX_MAG : (MAX_MAG - 1'b1);
    end else begin
      mag_sat = mag;
    end
    res_full = neg ? (~mag_sat + 1'b1) : mag_sat;
  end

  // output register
  logic                          out_valid_q;
  logic [CH_W-1:0]               out_channel_q;
  logic signed [SAMPLE_BITS-1:0] sample_out_q;
  logic                          clipped_q;
  logic                          last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_channel_q <= cmd_i.emit_row;
      sample_out_q  <= res_full[SAMPLE_BITS-1:0];
      clipped_q     <= clip;
      last_q        <= cmd_i.emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_channel_o   = out_channel_q;
  assign sample_out_o    = sample_out_q;
  assign clipped_o       = clipped_q;
  assign last_of_frame_o = last_q;

  assign sts_o.clear_done = (clr_cnt_q == AW'(DEPTH - 1));
  assign sts_o.busy       = s1_valid_q || s2_valid_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

FILE: sv/audio_channel_mixing_matrix_unit.sv
// top level of the audio channel mixing matrix
// Input channel: in_valid_i / in_stall_o. operation_i selects a coefficient word
// (coef_row_i, coef_col_i, coef_value_i, signed Q8.(COEF_BITS-8)) or a sample word
// (sample_in_i). Samples of a frame come one input channel at a time, in order.
// Output channel: out_valid_o / out_stall_i, one word per output channel, in order,
// with a clip flag and last_of_frame_o on the final channel of the frame.
// Config: cfg_valid_i / cfg_ready_o, index 0 input channel count, index 1 output
// channel count, both reset to 4; a write to either also drops any partial frame.
// One shared multiplier does one output channel per cycle for a sample word, fed
// from the registered read of the coefficient ram, with its read, multiply and
// accumulate stages drained before the next word is taken. After the last input
// channel, the frame is emitted at one word per cycle while the receiver does not
// stall. After reset the coefficient ram is cleared at one entry a cycle, all
// MAX_CHANNELS^2 entries (256 by default), with the input stalled; config writes
// are still taken. A stalled receiver holds the output register and the emission
// waits; the next input word is taken while the final result of a frame is still
// waiting.
module audio_channel_mixing_matrix_unit import acmm_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int COEF_BITS    = COEF_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [CH_W-1:0]               coef_row_i,
  input  logic [CH_W-1:0]               coef_col_i,
  input  logic signed [COEF_BITS-1:0]   coef_value_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [CH_W-1:0]               out_channel_o,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          clipped_o,
  output logic                          last_of_frame_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int CH_LIMIT = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(CH_LIMIT);

  logic [CNT_W-1:0] in_cnt_q, out_cnt_q;
  logic [CNT_W-1:0] in_count, out_count;
  logic             cfg_we;
  logic             cfg_hit;
  cmd_t             cmd;
  sts_t             sts;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_we && (cfg_index_i inside {REG_IN_COUNT, REG_OUT_COUNT});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= COUNT_RESET;
      out_cnt_q <= COUNT_RESET;
    end else if (cfg_we) begin
      if (cfg_index_i == REG_IN_COUNT) begin
        in_cnt_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_OUT_COUNT) begin
        out_cnt_q <= cfg_data_i;
      end
    end
  end

  // zero acts as one, anything past the channel limit as the limit
  always_comb begin
    in_count  = in_cnt_q;
    out_count = out_cnt_q;
    if (in_cnt_q == '0) begin
      in_count = 5'd1;
    end else if (in_cnt_q > LIMIT) begin
      in_count = LIMIT;
    end
    if (out_cnt_q == '0) begin
      out_count = 5'd1;
    end else if (out_cnt_q > LIMIT) begin
      out_count = LIMIT;
    end
  end

  acmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .in_count_i  (in_count),
    .out_count_i (out_count),
    .cfg_clear_i (cfg_hit),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  acmm_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .COEF_BITS    (COEF_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .coef_row_i      (coef_row_i),
    .coef_col_i      (coef_col_i),
    .coef_value_i    (coef_value_i),
    .sample_in_i     (sample_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_channel_o   (out_channel_o),
    .sample_out_o    (sample_out_o),
    .clipped_o       (clipped_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule
